// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the graph6 decoder.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define GSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define GSD_ASSERT_IMPL(label, ante, cons, msg) \
	`GSD_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/gsd_pkg.sv =====
// Package of the graph6 stream decoder: constants, codes, queue and result types.
// Used by every module of the decoder; depends on nothing.
`default_nettype none

package gsd_pkg;

	localparam int unsigned ORDER_BITS_DEF = 36;
	localparam int unsigned OUT_W          = 36;
	localparam int unsigned SIX_W          = 6;
	localparam int unsigned IN_TDATA_W     = 8;
	localparam int unsigned OUT_TDATA_W    = 112;
	localparam int unsigned OUT_TUSER_W    = 2;
	localparam int unsigned FIFO_DEPTH     = 4;
	localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CHAR_BIAS = 8'd63;
	localparam logic [7:0] LONG_MARK = 8'd126;
	localparam logic [2:0] HDR_SHORT = 3'd2;
	localparam logic [2:0] HDR_LONG  = 3'd6;
	localparam logic [2:0] LAST_BIT  = 3'd5;

	localparam logic KIND_ORDER = 1'b0;
	localparam logic KIND_BIT   = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TILDE,
		PH_HEADER,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic             kind;
		logic [SIX_W-1:0] six;
		logic [OUT_W-1:0] order;
	} q_entry_t;

	typedef struct packed {
		logic             kind;
		logic [OUT_W-1:0] order;
		logic [OUT_W-1:0] row;
		logic [OUT_W-1:0] col;
		logic             edge_res;
		logic             last_of_byte;
		logic             final_bit;
	} result_t;

	function automatic logic [SIX_W-1:0] char_bits(input logic [7:0] ch);
		logic [7:0] d;
		d = ch - CHAR_BIAS;
		return d[SIX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/gsd_fifo.sv =====
// Short register queue between the decoder front and back parts.
// Depends on gsd_pkg for the entry type and depth.
`default_nettype none

module gsd_fifo
	import gsd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_data,
	output logic          full,
	input  wire logic     pop,
	output q_entry_t      pop_data,
	output logic          empty
);

	q_entry_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W:0] wr_ptr_q;
	logic [FIFO_PTR_W:0] rd_ptr_q;

	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (wr_ptr_q[FIFO_PTR_W-1:0] == rd_ptr_q[FIFO_PTR_W-1:0]) &&
	                  (wr_ptr_q[FIFO_PTR_W] != rd_ptr_q[FIFO_PTR_W]);
	assign pop_data = mem_q[rd_ptr_q[FIFO_PTR_W-1:0]];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q[FIFO_PTR_W-1:0]] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gsd_front.sv =====
// Front part of the graph6 decoder: header parsing and character classification.
// Depends on gsd_pkg; pushes order reports and data characters into the queue.
`default_nettype none

module gsd_front
	import gsd_pkg::*;
#(
	parameter int unsigned ORDER_BITS = ORDER_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	input  wire logic       start_req,
	output logic            push,
	output q_entry_t        push_data
);

	phase_t                phase_q, phase_d;
	logic [ORDER_BITS-1:0] vc_q, vc_d;
	logic [2:0]            hl_q, hl_d;

	logic [SIX_W-1:0]      six;
	logic                  is_mark;
	logic [2:0]            hl_dec;
	logic [ORDER_BITS-1:0] vc_shift;

	assign six      = char_bits(in_byte);
	assign is_mark  = (in_byte == LONG_MARK);
	assign hl_dec   = hl_q - 3'd1;
	assign vc_shift = ORDER_BITS'({vc_q, six});

	// Next state.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (start_req) begin
				phase_d = is_mark ? PH_TILDE : PH_DATA;
			end else begin
				case (phase_q)
					PH_TILDE:  phase_d = PH_HEADER;
					PH_HEADER: phase_d = (hl_dec == 3'd0) ? PH_DATA : PH_HEADER;
					default:   phase_d = phase_q;
				endcase
			end
		end
	end

	// Datapath updates and queue pushes.
	always_comb begin
		vc_d      = vc_q;
		hl_d      = hl_q;
		push      = 1'b0;
		push_data = '0;
		if (accept) begin
			if (start_req) begin
				hl_d = 3'd0;
				if (is_mark) begin
					vc_d = '0;
				end else begin
					vc_d            = ORDER_BITS'(six);
					push            = 1'b1;
					push_data.kind  = KIND_ORDER;
					push_data.order = OUT_W'(vc_d);
				end
			end else begin
				case (phase_q)
					PH_TILDE: begin
						if (is_mark) begin
							hl_d = HDR_LONG;
						end else begin
							vc_d = ORDER_BITS'(six);
							hl_d = HDR_SHORT;
						end
					end
					PH_HEADER: begin
						vc_d = vc_shift;
						hl_d = hl_dec;
						if (hl_dec == 3'd0) begin
							push            = 1'b1;
							push_data.kind  = KIND_ORDER;
							push_data.order = OUT_W'(vc_shift);
						end
					end
					PH_DATA: begin
						push            = 1'b1;
						push_data.kind  = KIND_BIT;
						push_data.six   = six;
						push_data.order = OUT_W'(vc_q);
					end
					default: begin
						push = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			vc_q    <= '0;
			hl_q    <= '0;
		end else begin
			phase_q <= phase_d;
			vc_q    <= vc_d;
			hl_q    <= hl_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/gsd_back.sv =====
// Back part of the graph6 decoder: expands queued characters into results.
// Depends on gsd_pkg; walks the upper triangle and drives the result register.
`default_nettype none

module gsd_back
	import gsd_pkg::*;
#(
	parameter int unsigned ORDER_BITS = ORDER_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     q_empty,
	input  wire q_entry_t q_data,
	output logic          q_pop,
	output logic          out_valid,
	input  wire logic     out_ready,
	output result_t       out_res
);

	// Entry under expansion.
	logic                  w_valid_q;
	logic                  w_kind_q;
	logic [SIX_W-1:0]      w_six_q;
	logic [ORDER_BITS-1:0] w_order_q;
	logic [2:0]            w_k_q;

	// Triangle walk.
	logic [ORDER_BITS-1:0] row_q;
	logic [ORDER_BITS-1:0] col_q;
	logic                  done_q;

	logic                  out_valid_q;
	result_t               res_q;

	logic                  load_ok, skip, emit, last, w_done;
	logic [ORDER_BITS-1:0] rn, cn;
	logic                  hit, fin;

	assign load_ok = !out_valid_q || out_ready;
	assign skip    = w_valid_q && (w_kind_q == KIND_BIT) && done_q;
	assign emit    = w_valid_q && !skip && load_ok;

	assign rn  = row_q + 1'b1;
	assign cn  = col_q + 1'b1;
	assign hit = (rn == col_q);
	assign fin = hit && ((cn >= w_order_q) || (cn == '0));

	assign last   = (w_kind_q == KIND_ORDER) || fin || (w_k_q == 3'd0);
	assign w_done = skip || (emit && last);
	assign q_pop  = !q_empty && (!w_valid_q || w_done);

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_valid_q   <= 1'b0;
			out_valid_q <= 1'b0;
			done_q      <= 1'b1;
		end else begin
			if (q_pop) begin
				w_valid_q <= 1'b1;
			end else if (w_done) begin
				w_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				if (w_kind_q == KIND_ORDER) begin
					done_q <= (w_order_q < ORDER_BITS'(2));
				end else if (fin) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			w_kind_q  <= q_data.kind;
			w_six_q   <= q_data.six;
			w_order_q <= ORDER_BITS'(q_data.order);
			w_k_q     <= LAST_BIT;
		end else if (emit) begin
			w_k_q <= w_k_q - 3'd1;
		end
		if (emit) begin
			res_q.kind         <= w_kind_q;
			res_q.order        <= OUT_W'(w_order_q);
			res_q.last_of_byte <= last;
			if (w_kind_q == KIND_ORDER) begin
				res_q.row       <= '0;
				res_q.col       <= '0;
				res_q.edge_res  <= 1'b0;
				res_q.final_bit <= 1'b0;
				row_q           <= '0;
				col_q           <= ORDER_BITS'(1);
			end else begin
				res_q.row       <= OUT_W'(row_q);
				res_q.col       <= OUT_W'(col_q);
				res_q.edge_res  <= w_six_q[w_k_q];
				res_q.final_bit <= fin;
				if (hit) begin
					row_q <= '0;
					col_q <= cn;
				end else begin
					row_q <= rn;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/graph6_stream_decoder.sv =====
// graph6 stream decoder: one character per transaction, order and matrix bits out.
// Path: an accepted character passes the queue, entry register and result register.
// Throughput: one input transaction per cycle while the queue has room; one result
// per cycle out unless m_tready stalls it; a data character yields up to six results.
// Reset (arst_n low, asynchronous) empties the queue and waits for a start character.
`default_nettype none

module graph6_stream_decoder
	import gsd_pkg::*;
#(
	parameter int unsigned ORDER_BITS = ORDER_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input transactions.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [7:0] in_byte
	input  wire logic                   s_tuser,  // [0] start_req
	// Result transactions.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // order, row, col, edge_res, zero pad
	output logic [OUT_TUSER_W-1:0]      m_tuser,  // [0] kind, [1] final_bit
	output logic                        m_tlast   // last_of_byte
);

	// The front part parses the header and tags every character that matters;
	// order reports and data characters wait in a four-entry queue. The back part
	// pops an entry while its last result goes out, so consecutive characters
	// stream without a gap. Characters that follow the final bit of a graph are
	// dropped in the back part without producing results.

	logic     accept;
	logic     push;
	q_entry_t push_data;
	logic     q_full;
	logic     q_empty;
	logic     q_pop;
	q_entry_t q_data;
	result_t  res;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	gsd_front #(
		.ORDER_BITS (ORDER_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_tdata),
		.start_req (s_tuser),
		.push      (push),
		.push_data (push_data)
	);

	gsd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	gsd_back #(
		.ORDER_BITS (ORDER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Result packing, lowest field first.
	assign m_tdata = {3'b000, res.edge_res, res.col, res.row, res.order};
	assign m_tuser = {res.final_bit, res.kind};
	assign m_tlast = res.last_of_byte;

endmodule

`default_nettype wire

// ===== rtl/gsd_checker.sv =====
// Port-level checker for the graph6 stream decoder, bound to the top level.
// Depends on gsd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gsd_checker
	import gsd_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic [OUT_TUSER_W-1:0] m_tuser,
	input wire logic                   m_tlast
);

	// An order report closes its character and carries no pair.
	`GSD_ASSERT_IMPL(a_order_report, m_tvalid && !m_tuser[0], m_tlast && !m_tuser[1] && (m_tdata[108:36] == '0), "order report malformed")

	// Matrix bits always address the strict upper triangle.
	`GSD_ASSERT_IMPL(a_upper_tri, m_tvalid && m_tuser[0], m_tdata[71:36] < m_tdata[107:72], "row not below col")

	// The final bit of a graph is a matrix bit that closes its character.
	`GSD_ASSERT_IMPL(a_final_last, m_tvalid && m_tuser[1], m_tlast && m_tuser[0], "final bit not last")

	// A stalled result stays put.
	`GSD_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

endmodule

bind graph6_stream_decoder gsd_checker u_gsd_checker (.*);

`default_nettype wire
